### hw/rtl/bal_pkg.sv
`default_nettype none

package bal_pkg;

    // store geometry
    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;

    typedef enum logic [1:0] {
        FN_APPEND = 2'd0,
        FN_READ   = 2'd1,
        FN_WRITE  = 2'd2,
        FN_REMOVE = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_OOB  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_READ  = 2'd1,
        S_SHIFT = 2'd2
    } t_state;

    // store read address source
    typedef enum logic [1:0] {
        RD_INDEX    = 2'd0,
        RD_INDEX_P1 = 2'd1,
        RD_PTR_P2   = 2'd2
    } t_rd_sel;

    // store write address/data source
    typedef enum logic [1:0] {
        WR_TAIL  = 2'd0,
        WR_INDEX = 2'd1,
        WR_PTR   = 2'd2
    } t_wr_sel;

    typedef struct packed {
        logic    mem_rd;
        t_rd_sel rd_sel;
        logic    mem_wr;
        t_wr_sel wr_sel;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    ptr_load;
        logic    ptr_inc;
        logic    finish;
        t_status fin_status;
        logic    fin_rdata;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic oob;
        logic rm_tail;
        logic shift_last;
    } t_dp_sts;

endpackage

`default_nettype wire

### hw/rtl/bal_ctrl.sv
`default_nettype none

module bal_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [1:0]       i_func,
    input  bal_pkg::t_dp_sts i_sts,
    output bal_pkg::t_dp_cmd o_cmd,
    output logic             o_busy
);

    bal_pkg::t_state r_state;
    bal_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bal_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != bal_pkg::S_IDLE);

    always_comb begin
        n_state          = r_state;
        o_cmd.mem_rd     = 1'b0;
        o_cmd.rd_sel     = bal_pkg::RD_INDEX;
        o_cmd.mem_wr     = 1'b0;
        o_cmd.wr_sel     = bal_pkg::WR_TAIL;
        o_cmd.cnt_inc    = 1'b0;
        o_cmd.cnt_dec    = 1'b0;
        o_cmd.ptr_load   = 1'b0;
        o_cmd.ptr_inc    = 1'b0;
        o_cmd.finish     = 1'b0;
        o_cmd.fin_status = bal_pkg::ST_OK;
        o_cmd.fin_rdata  = 1'b0;
        unique case (r_state)
            bal_pkg::S_IDLE: begin
                if (i_start) begin
                    unique case (bal_pkg::t_func'(i_func))
                        bal_pkg::FN_APPEND: begin
                            o_cmd.finish = 1'b1;
                            if (i_sts.full) begin
                                o_cmd.fin_status = bal_pkg::ST_FULL;
                            end else begin
                                o_cmd.mem_wr  = 1'b1;
                                o_cmd.wr_sel  = bal_pkg::WR_TAIL;
                                o_cmd.cnt_inc = 1'b1;
                            end
                        end
                        bal_pkg::FN_READ: begin
                            if (i_sts.oob) begin
                                o_cmd.finish     = 1'b1;
                                o_cmd.fin_status = bal_pkg::ST_OOB;
                            end else begin
                                o_cmd.mem_rd = 1'b1;
                                o_cmd.rd_sel = bal_pkg::RD_INDEX;
                                n_state      = bal_pkg::S_READ;
                            end
                        end
                        bal_pkg::FN_WRITE: begin
                            o_cmd.finish = 1'b1;
                            if (i_sts.oob) begin
                                o_cmd.fin_status = bal_pkg::ST_OOB;
                            end else begin
                                o_cmd.mem_wr = 1'b1;
                                o_cmd.wr_sel = bal_pkg::WR_INDEX;
                            end
                        end
                        bal_pkg::FN_REMOVE: begin
                            if (i_sts.oob) begin
                                o_cmd.finish     = 1'b1;
                                o_cmd.fin_status = bal_pkg::ST_OOB;
                            end else if (i_sts.rm_tail) begin
                                o_cmd.finish  = 1'b1;
                                o_cmd.cnt_dec = 1'b1;
                            end else begin
                                o_cmd.mem_rd   = 1'b1;
                                o_cmd.rd_sel   = bal_pkg::RD_INDEX_P1;
                                o_cmd.ptr_load = 1'b1;
                                n_state        = bal_pkg::S_SHIFT;
                            end
                        end
                        default: begin
                            n_state = bal_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            bal_pkg::S_READ: begin
                o_cmd.finish    = 1'b1;
                o_cmd.fin_rdata = 1'b1;
                n_state         = bal_pkg::S_IDLE;
            end
            bal_pkg::S_SHIFT: begin
                // move the fetched word down one place
                o_cmd.mem_wr  = 1'b1;
                o_cmd.wr_sel  = bal_pkg::WR_PTR;
                o_cmd.ptr_inc = 1'b1;
                if (i_sts.shift_last) begin
                    o_cmd.finish  = 1'b1;
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = bal_pkg::S_IDLE;
                end else begin
                    o_cmd.mem_rd = 1'b1;
                    o_cmd.rd_sel = bal_pkg::RD_PTR_P2;
                end
            end
            default: begin
                n_state = bal_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/bal_dp.sv
`default_nettype none

module bal_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bal_pkg::t_dp_cmd               i_cmd,
    output bal_pkg::t_dp_sts               o_sts,
    input  logic [bal_pkg::ADDR_W-1:0]     i_index,
    input  logic signed [bal_pkg::WORD_W-1:0] i_value,
    input  logic                           i_cfg_valid,
    input  logic [bal_pkg::CNT_W-1:0]      i_cfg_data,
    output logic                           o_cfg_ready,
    output logic                           o_done,
    output logic signed [bal_pkg::WORD_W-1:0] o_read_value,
    output logic [1:0]                     o_status,
    output logic [bal_pkg::CNT_W-1:0]      o_count
);

    localparam int AW = bal_pkg::ADDR_W;
    localparam int CW = bal_pkg::CNT_W;
    localparam int WW = bal_pkg::WORD_W;

    logic [WW-1:0] r_mem [bal_pkg::DEPTH];
    logic [WW-1:0] r_rdata;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_limit;
    logic [AW-1:0] r_ptr;
    logic          r_done;
    logic [WW-1:0] r_read_value;
    logic [1:0]    r_status;
    logic [CW-1:0] r_count_out;

    logic [CW-1:0] lim_eff;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [WW-1:0] wr_data;

    assign o_cfg_ready = 1'b1;

    // limit in force never exceeds the store depth
    assign lim_eff = (r_limit > CW'(bal_pkg::DEPTH)) ? CW'(bal_pkg::DEPTH) : r_limit;

    assign o_sts.full       = (r_count >= lim_eff);
    assign o_sts.oob        = (CW'(i_index) >= r_count);
    assign o_sts.rm_tail    = ((CW'(i_index) + CW'(1)) >= r_count);
    assign o_sts.shift_last = ((CW'(r_ptr) + CW'(2)) >= r_count);

    always_comb begin
        unique case (i_cmd.rd_sel)
            bal_pkg::RD_INDEX:    rd_addr = i_index;
            bal_pkg::RD_INDEX_P1: rd_addr = i_index + AW'(1);
            bal_pkg::RD_PTR_P2:   rd_addr = r_ptr + AW'(2);
            default:              rd_addr = i_index;
        endcase
    end

    always_comb begin
        unique case (i_cmd.wr_sel)
            bal_pkg::WR_TAIL: begin
                wr_addr = r_count[AW-1:0];
                wr_data = i_value;
            end
            bal_pkg::WR_INDEX: begin
                wr_addr = i_index;
                wr_data = i_value;
            end
            bal_pkg::WR_PTR: begin
                wr_addr = r_ptr;
                wr_data = r_rdata;
            end
            default: begin
                wr_addr = i_index;
                wr_data = i_value;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - CW'(1);
        end
    end

    // element store, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_limit <= CW'(bal_pkg::DEPTH);
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= i_cmd.finish;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ptr_load) begin
            r_ptr <= i_index;
        end else if (i_cmd.ptr_inc) begin
            r_ptr <= r_ptr + AW'(1);
        end
        if (i_cmd.finish) begin
            r_read_value <= i_cmd.fin_rdata ? r_rdata : '0;
            r_status     <= i_cmd.fin_status;
            r_count_out  <= n_count;
        end
    end

    assign o_done       = r_done;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign o_count      = r_count_out;

endmodule

`default_nettype wire

### hw/rtl/bounded_array_list_unit.sv
`default_nettype none

// bounded list of signed 32-bit words with append, read, overwrite and
// shifting remove
// request channel: an item is taken at a clock edge with start high and
// busy low; i_func selects the operation, i_index the position, i_value
// the word to store
// result channel: o_done is high for exactly one cycle per request, with
// o_read_value, o_status and o_count valid in that cycle; the receiver
// cannot hold it off, so every beat must be taken when it shows
// config channel: i_cfg_valid/o_cfg_ready write i_cfg_data into the
// capacity limit; ready is always high, writes belong to idle periods
// fast path: append, overwrite and every failing request show o_done the
// cycle after acceptance while busy stays low, so these run one per cycle
// a read passes through S_READ, as the store read port is registered
// a remove at the tail only drops the count; one below it walks S_SHIFT:
// the single store write port moves one word a cycle through the gap
// reset clears the count, sets the limit to 64 and drops busy and o_done;
// store contents are undefined until written

module bounded_array_list_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_func,
    input  logic [5:0]         i_index,
    input  logic signed [31:0] i_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [6:0]         i_cfg_data,
    output logic               o_done,
    output logic signed [31:0] o_read_value,
    output logic [1:0]         o_status,
    output logic [6:0]         o_count
);

    // command and status between sequencer and datapath
    bal_pkg::t_dp_cmd cmd;
    bal_pkg::t_dp_sts sts;

    bal_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_func),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    bal_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_index      (i_index),
        .i_value      (i_value),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_cfg_ready  (o_cfg_ready),
        .o_done       (o_done),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_count      (o_count)
    );

    // the count never grows past the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_count <= 7'(bal_pkg::DEPTH)))
        else $error("count beyond store depth");

    // a failed request never returns data
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != bal_pkg::ST_OK)) |-> (o_read_value == '0))
        else $error("failed request returned data");

    // an append always finishes in the cycle it is taken
    a_append_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_func == bal_pkg::FN_APPEND)) |=> (o_done && !busy))
        else $error("append did not finish in one cycle");

    // a result beat only shows once the sequencer is back in idle
    a_no_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_done)
        else $error("result beat while busy");

endmodule

`default_nettype wire
